>>> rtl/tgrc_pkg.sv
// ----------------------------------------------------------------------------
// tgrc_pkg
// Shared constants, types and helpers for the text grid run counter.
// ----------------------------------------------------------------------------
package tgrc_pkg;

    localparam int MAX_CHARS = 128;
    localparam int RUN_LEN   = 5;

    localparam int COL_W   = $clog2(MAX_CHARS);
    localparam int RUN_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  HCHAR_RESET  = 8'd104;
    localparam logic [CHAR_W-1:0]  VCHAR_RESET  = 8'd118;
    localparam logic [RUN_W-1:0]   RUN_LEN_V    = RUN_W'(RUN_LEN);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_CHAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_CHAR   = 1'd1;

    typedef logic [RUN_W-1:0] run_t;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic shift;
        logic insert_blank;
    } chain_ctrl_t;

    function automatic run_t advance_run(input run_t run, input logic match);
        run_t res;
        if (!match) begin
            res = '0;
        end else if (run < RUN_LEN_V) begin
            res = run + run_t'(1);
        end else begin
            res = RUN_LEN_V;
        end
        return res;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

endpackage

>>> rtl/tgrc_cell.sv
// ----------------------------------------------------------------------------
// tgrc_cell
// One column cell: holds the vertical run of one column and passes it on.
// ----------------------------------------------------------------------------
module tgrc_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift,
    input  tgrc_pkg::run_t   run_in,
    output tgrc_pkg::run_t   run_out
);
    import tgrc_pkg::*;

    run_t run_reg;
    run_t run_next;

    always_comb begin
        run_next = shift ? run_in : run_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else begin
            run_reg <= run_next;
        end
    end

    assign run_out = run_reg;

endmodule

>>> rtl/tgrc_chain.sv
// ----------------------------------------------------------------------------
// tgrc_chain
// Ring of column cells. The head cell holds the current column; each shift
// moves the ring one column on and writes the updated run, or a blank, in at the tail.
// ----------------------------------------------------------------------------
module tgrc_chain (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tgrc_pkg::chain_ctrl_t  ctrl,
    input  tgrc_pkg::run_t         tail_in,
    output tgrc_pkg::run_t         head_out
);
    import tgrc_pkg::*;

    run_t links [MAX_CHARS];
    run_t tail_val;

    assign tail_val = ctrl.insert_blank ? run_t'(0) : tail_in;

    for (genvar k = 0; k < MAX_CHARS; k++) begin : g_cell
        run_t cell_in;
        if (k == MAX_CHARS - 1) begin : g_tail
            assign cell_in = tail_val;
        end else begin : g_body
            assign cell_in = links[k+1];
        end
        tgrc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (ctrl.shift),
            .run_in  (cell_in),
            .run_out (links[k])
        );
    end

    assign head_out = links[0];

endmodule

>>> rtl/text_grid_run_counter.sv
// ----------------------------------------------------------------------------
// text_grid_run_counter
// Counts horizontal and vertical runs of match characters in a text grid.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_text_char carries one character per transfer.
//   m_valid/m_ready carries both running totals after every character.
//   cfg_we/cfg_index/cfg_wdata writes the horizontal (index 0) and vertical
//   (index 1) match characters; write only while the block is idle.
// Latency: the totals of a character are presented the cycle after its
//   transfer.
// Throughput: one character per cycle while the result register is free. A
//   newline before the last column sends the column ring rotating back to
//   column 0, clearing the unreached columns; s_ready is low meanwhile.
// Stall: the result register holds until taken; a new character is taken
//   in the same cycle the waiting result is taken.
// Reset: synchronous, active low; clears totals, all column runs, column
//   position and the match characters to 'h' and 'v'.
// ----------------------------------------------------------------------------
module text_grid_run_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tgrc_pkg::CHAR_W-1:0]       s_text_char,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tgrc_pkg::TOTAL_W-1:0]      m_horizontal_total,
    output logic [tgrc_pkg::TOTAL_W-1:0]      m_vertical_total,
    input  logic                              cfg_we,
    input  logic [tgrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgrc_pkg::CHAR_W-1:0]       cfg_wdata
);
    import tgrc_pkg::*;

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   clr_reg, clr_next;
    run_t               hrun_reg, hrun_next;
    logic [TOTAL_W-1:0] hcount_reg, hcount_next;
    logic [TOTAL_W-1:0] vcount_reg, vcount_next;
    logic [CHAR_W-1:0]  hchar_reg, vchar_reg;
    logic               mvalid_reg, mvalid_next;

    chain_ctrl_t        chain_ctrl;
    run_t               head_run;
    run_t               hrun_adv;
    run_t               vrun_adv;
    logic               accept;
    logic               last_col;
    logic               row_end;
    logic               out_free;

    tgrc_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (chain_ctrl),
        .tail_in  (vrun_adv),
        .head_out (head_run)
    );

    assign out_free = !mvalid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign last_col = (col_reg == COL_W'(MAX_CHARS - 1));
    assign row_end  = (s_text_char == NEWLINE_CODE) || last_col;
    assign hrun_adv = advance_run(hrun_reg, s_text_char == hchar_reg);
    assign vrun_adv = advance_run(head_run, s_text_char == vchar_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (accept && row_end && !last_col) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (clr_reg == '0) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready                 = 1'b0;
        chain_ctrl.shift        = 1'b0;
        chain_ctrl.insert_blank = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_ready          = out_free;
                chain_ctrl.shift = s_valid && out_free;
            end
            ST_CLEAR: begin
                chain_ctrl.shift        = 1'b1;
                chain_ctrl.insert_blank = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        col_next    = col_reg;
        clr_next    = clr_reg;
        hrun_next   = hrun_reg;
        hcount_next = hcount_reg;
        vcount_next = vcount_reg;
        mvalid_next = mvalid_reg && !m_ready;
        if (state_reg == ST_CLEAR) begin
            clr_next = clr_reg - COL_W'(1);
        end
        if (accept) begin
            mvalid_next = 1'b1;
            if (hrun_adv == RUN_LEN_V) begin
                hcount_next = sat_inc(hcount_reg);
            end
            if (vrun_adv == RUN_LEN_V) begin
                vcount_next = sat_inc(vcount_reg);
            end
            if (row_end) begin
                col_next  = '0;
                hrun_next = '0;
                clr_next  = COL_W'(MAX_CHARS - 2) - col_reg;
            end else begin
                col_next  = col_reg + COL_W'(1);
                hrun_next = hrun_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_RUN;
            col_reg    <= '0;
            clr_reg    <= '0;
            hrun_reg   <= '0;
            hcount_reg <= '0;
            vcount_reg <= '0;
            mvalid_reg <= 1'b0;
            hchar_reg  <= HCHAR_RESET;
            vchar_reg  <= VCHAR_RESET;
        end else begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            clr_reg    <= clr_next;
            hrun_reg   <= hrun_next;
            hcount_reg <= hcount_next;
            vcount_reg <= vcount_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we && cfg_index == REG_HORIZONTAL_CHAR) begin
                hchar_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == REG_VERTICAL_CHAR) begin
                vchar_reg <= cfg_wdata;
            end
        end
    end

    assign m_valid            = mvalid_reg;
    assign m_horizontal_total = hcount_reg;
    assign m_vertical_total   = vcount_reg;

endmodule

>>> rtl/tgrc_checker.sv
// ----------------------------------------------------------------------------
// tgrc_checker
// Port-level checks for text_grid_run_counter, bound to the top level.
// ----------------------------------------------------------------------------
module tgrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_horizontal_total,
    input logic [31:0] m_vertical_total
);

    // result waits for its transfer
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after input transfer");

    a_totals_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=>
            $stable(m_horizontal_total) && $stable(m_vertical_total))
        else $error("totals changed without input transfer");

    a_step_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=>
            (m_horizontal_total == $past(m_horizontal_total) ||
             m_horizontal_total == $past(m_horizontal_total) + 32'd1) &&
            (m_vertical_total == $past(m_vertical_total) ||
             m_vertical_total == $past(m_vertical_total) + 32'd1))
        else $error("total moved by more than one");

endmodule

bind text_grid_run_counter tgrc_checker u_tgrc_checker (.*);

>>> tb/text_grid_run_counter_test.sv
// ----------------------------------------------------------------------------
// text_grid_run_counter_test
// Self-checking bench for the text grid run counter. Characters go in over
// the s_ handshake and both running totals come back over the m_ handshake.
// A behavioral copy of the grid state predicts the totals for every
// character. The bench runs directed rows for long horizontal runs, stacked
// vertical runs, newline as the match character and full-width rows. It
// then runs repeated row patterns with random mutations under several
// match-character settings. Both sides idle at random, with one long output
// hold-off.
// ----------------------------------------------------------------------------
module text_grid_run_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tgrc_pkg::*;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef struct packed {
        total_t horizontal;
        total_t vertical;
    } totals_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    char_t                s_text_char   = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    total_t               m_horizontal_total;
    total_t               m_vertical_total;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    char_t                cfg_wdata     = '0;

    // grid state as the block should hold it
    char_t   hmatch_char = HCHAR_RESET;
    char_t   vmatch_char = VCHAR_RESET;
    run_t    col_runs [MAX_CHARS] = '{default: '0};
    int      col_pos     = 0;
    run_t    row_run     = '0;
    total_t  h_count     = '0;
    total_t  v_count     = '0;
    totals_t expected_totals [$];

    bit steady      = 1'b0;
    bit long_hold   = 1'b0;
    int error_count    = 0;
    int chars_sent     = 0;
    int rows_sent      = 0;
    int totals_checked = 0;
    int reg_writes     = 0;

    always #4 aclk = ~aclk;

    text_grid_run_counter dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_text_char        (s_text_char),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_horizontal_total (m_horizontal_total),
        .m_vertical_total   (m_vertical_total),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    function automatic run_t grow_run(input run_t r, input logic hit);
        if (!hit) return '0;
        if (r < run_t'(RUN_LEN)) return r + run_t'(1);
        return run_t'(RUN_LEN);
    endfunction

    function automatic total_t bump_total(input total_t t);
        return (t == '1) ? t : t + total_t'(1);
    endfunction

    // advance the grid by one character and queue the totals it leaves
    function automatic void count_runs(input char_t ch);
        int col;
        int c;
        col = col_pos;
        row_run = grow_run(row_run, ch == hmatch_char);
        if (row_run == run_t'(RUN_LEN)) h_count = bump_total(h_count);
        col_runs[col] = grow_run(col_runs[col], ch == vmatch_char);
        if (col_runs[col] == run_t'(RUN_LEN)) v_count = bump_total(v_count);
        if (ch == NEWLINE_CODE || col == MAX_CHARS - 1) begin
            for (c = col + 1; c < MAX_CHARS; c++) col_runs[c] = '0;
            col_pos = 0;
            row_run = '0;
            rows_sent++;
        end else begin
            col_pos = col + 1;
        end
        expected_totals.push_back('{h_count, v_count});
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 20) $display("MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    task automatic send_char(input char_t ch);
        if (!steady) begin
            while ($urandom_range(0, 99) < 23) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_text_char <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        count_runs(ch);
        chars_sent++;
    endtask

    // stop offering and wait for every outstanding result; settle also lets
    // a trailing column clear finish
    task automatic drain(input bit settle);
        s_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge aclk);
        if (settle) repeat (MAX_CHARS + 8) @(posedge aclk);
    endtask

    task automatic write_match_chars(input char_t hch, input char_t vch);
        drain(1'b1);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HORIZONTAL_CHAR;
        cfg_wdata <= hch;
        @(posedge aclk);
        cfg_index <= REG_VERTICAL_CHAR;
        cfg_wdata <= vch;
        @(posedge aclk);
        cfg_we <= 1'b0;
        hmatch_char = hch;
        vmatch_char = vch;
        reg_writes += 2;
    endtask

    // one row pattern repeated a few times with mutations, so that columns
    // line up across rows
    task automatic send_row_group();
        char_t pattern [MAX_CHARS];
        int    width;
        int    len;
        int    copies;
        int    pick;
        if ($urandom_range(0, 19) == 0) begin
            width  = $urandom_range(20, MAX_CHARS);
            copies = $urandom_range(1, 2);
        end else begin
            width  = $urandom_range(1, 10);
            copies = $urandom_range(2, 8);
        end
        for (int i = 0; i < width; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      pattern[i] = vmatch_char;
            else if (pick < 70) pattern[i] = hmatch_char;
            else if (pick < 97) pattern[i] = char_t'($urandom_range(0, 255));
            else                pattern[i] = NEWLINE_CODE;
        end
        repeat (copies) begin
            len = ($urandom_range(0, 99) < 15) ? $urandom_range(0, width - 1) : width;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < 8) send_char(char_t'($urandom_range(0, 255)));
                else send_char(pattern[i]);
            end
            if (len < MAX_CHARS) send_char(NEWLINE_CODE);
        end
    endtask

    task automatic test_horizontal_runs();
        repeat (6) send_char(hmatch_char);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(NEWLINE_CODE);
    endtask

    task automatic test_vertical_columns();
        repeat (5) begin
            send_char(vmatch_char);
            send_char(NEWLINE_CODE);
        end
        send_char(NEWLINE_CODE);
    endtask

    task automatic test_newline_match();
        write_match_chars(NEWLINE_CODE, NEWLINE_CODE);
        repeat (5) send_char(NEWLINE_CODE);
    endtask

    task automatic test_full_rows();
        write_match_chars(8'h2A, 8'h2A);
        steady = 1'b1;
        repeat (5 * MAX_CHARS) begin
            if ($urandom_range(0, 4) != 0) send_char(8'h2A);
            else send_char(char_t'($urandom_range(11, 255)));
        end
        drain(1'b0);
        steady = 1'b0;
    endtask

    task automatic test_result_backpressure();
        int target;
        write_match_chars(char_t'($urandom_range(0, 255)), char_t'($urandom_range(0, 255)));
        long_hold = 1'b1;
        target = chars_sent + 60;
        while (chars_sent < target) send_row_group();
        drain(1'b0);
    endtask

    task automatic test_random_phases();
        char_t phase_h [6];
        char_t phase_v [6];
        int    target;
        phase_h = '{HCHAR_RESET, 8'h00, 8'hFF, NEWLINE_CODE, 8'h61, 8'h00};
        phase_v = '{VCHAR_RESET, 8'hFF, 8'h00, NEWLINE_CODE, 8'h61, 8'h00};
        phase_h[5] = char_t'($urandom_range(0, 255));
        phase_v[5] = char_t'($urandom_range(0, 255));
        for (int p = 0; p < 6; p++) begin
            write_match_chars(phase_h[p], phase_v[p]);
            target = chars_sent + 180;
            while (chars_sent < target) begin
                send_row_group();
                if (p == 2 && $urandom_range(0, 9) == 0) drain(1'b0);
            end
        end
    endtask

    initial begin : result_sink
        int held;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                for (held = 1; held < 300; held++) @(posedge aclk);
                long_hold = 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 23);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        totals_t want;
        if (aresetn && m_valid && m_ready) begin
            totals_checked++;
            if (expected_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer h=%0d v=%0d",
                    m_horizontal_total, m_vertical_total));
            end else begin
                want = expected_totals.pop_front();
                if (m_horizontal_total !== want.horizontal)
                    report_mismatch($sformatf("horizontal_total %0d, expected %0d",
                        m_horizontal_total, want.horizontal));
                if (m_vertical_total !== want.vertical)
                    report_mismatch($sformatf("vertical_total %0d, expected %0d",
                        m_vertical_total, want.vertical));
            end
        end
    end

    initial begin
        #20ms;
        $display("timed out with %0d results outstanding", expected_totals.size());
        $display("text_grid_run_counter_test: errors");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_horizontal_runs();
        test_vertical_columns();
        test_newline_match();
        test_full_rows();
        test_result_backpressure();
        test_random_phases();
        drain(1'b1);
        $display("%0d characters in %0d rows, %0d result transfers checked",
            chars_sent, rows_sent, totals_checked);
        $display("%0d match character writes, final totals horizontal %0d vertical %0d",
            reg_writes, h_count, v_count);
        if (error_count == 0) begin
            $display("text_grid_run_counter_test: clean");
        end else begin
            $display("text_grid_run_counter_test: errors");
        end
        $finish;
    end

endmodule
